FILE: hdl/mlss_pkg.sv
// Package: shared widths, payload structs and controller/datapath links
`timescale 1ns / 1ps
package mlss_pkg;

    localparam int DEF_MAX_PIXELS = 262144;
    localparam int CNT_W   = 19;
    localparam int SX_W    = 34;
    localparam int SY_W    = 44;
    localparam int SXX_W   = 48;
    localparam int SXY_W   = 58;
    localparam int OP_W    = 58;
    localparam int PROD_W  = 80;
    localparam int DVD_W   = 104;
    localparam int DSR_W   = 82;
    localparam int SLOPE_W = 48;
    localparam int FRAC_SHIFT = 23;
    localparam int BIT_CNT_W  = 6;
    localparam int DIV_CNT_W  = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DAT_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_MEAN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_EXP    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_LIMIT  = 8'd2;

    typedef struct packed {
        logic [15:0] pixel_value;
        logic [15:0] flux_fraction;
        logic        pixel_enabled;
        logic        last_pixel;
    } t_in_item;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic [CNT_W-1:0]          used_count;
        logic                      degenerate;
        logic                      clipped;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic mul_y;
        logic mul_sq;
        logic accum;
        logic prod_load;
        logic prod_step;
        logic form;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic prod_done;
        logic prod_final;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

FILE: hdl/mlss_ctrl.sv
// Controller: sequences per-pixel accumulation and the end-of-image fit
`timescale 1ns / 1ps
module mlss_ctrl
    import mlss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MULY  = 9'b000000010,
        S_SQ    = 9'b000000100,
        S_ACC   = 9'b000001000,
        S_PLOAD = 9'b000010000,
        S_PROD  = 9'b000100000,
        S_FORM  = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_LOAD  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_MULY;
                end
            end
            S_MULY: begin
                o_cmd.mul_y = 1'b1;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.mul_sq = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                n_state = i_status.last ? S_PLOAD : S_IDLE;
            end
            S_PLOAD: begin
                o_cmd.prod_load = 1'b1;
                n_state = S_PROD;
            end
            S_PROD: begin
                o_cmd.prod_step = 1'b1;
                if (i_status.prod_done) begin
                    n_state = i_status.prod_final ? S_FORM : S_PLOAD;
                end
            end
            S_FORM: begin
                o_cmd.form = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                // the first div_step here preps the divider, later ones step it
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/mlss_dp.sv
// Datapath: config registers, sums, shared serial multiplier and divider
`timescale 1ns / 1ps
module mlss_dp
    import mlss_pkg::*;
#(
    parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  t_in_item             i_item,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output t_out_item            o_out_data
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

    logic [15:0] r_mean, r_sat;
    logic [23:0] r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0;
            r_inv  <= 24'd65536;
            r_sat  <= 16'd62000;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_IMAGE_MEAN) r_mean <= i_cfg_data[15:0];
            if (i_cfg_index == REG_INV_EXP)    r_inv  <= i_cfg_data[23:0];
            if (i_cfg_index == REG_SAT_LIMIT)  r_sat  <= i_cfg_data[15:0];
        end
    end

    // ---------------- per-pixel path ----------------
    logic signed [16:0] r_x, r_d;
    logic               r_keep, r_last;
    logic signed [41:0] r_py;
    logic signed [33:0] r_xx;
    logic signed [42:0] r_xy;
    logic signed [25:0] r_y;

    logic [CNT_W-1:0]        r_cnt;
    logic signed [SX_W-1:0]  r_sx;
    logic signed [SY_W-1:0]  r_sy;
    logic signed [SXX_W-1:0] r_sxx;
    logic signed [SXY_W-1:0] r_sxy;

    logic signed [33:0] w_yr;
    logic signed [25:0] w_y;

    always_comb begin
        w_yr = 34'((r_py + 42'sd128) >>> 8);
        if (w_yr > 34'sd33554431)       w_y = 26'sh1FFFFFF;
        else if (w_yr < -34'sd33554432) w_y = 26'sh2000000;
        else                            w_y = w_yr[25:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x    <= $signed({1'b0, i_item.flux_fraction}) - 17'sd16384;
            r_d    <= $signed({1'b0, i_item.pixel_value}) - $signed({1'b0, r_mean});
            r_keep <= i_item.pixel_enabled && (i_item.pixel_value < r_sat)
                      && (r_cnt < MAX_CNT);
            r_last <= i_item.last_pixel;
        end
        if (i_cmd.mul_y) begin
            r_py <= 42'(r_d * $signed({1'b0, r_inv}));
        end
        if (i_cmd.mul_sq) begin
            r_y  <= w_y;
            r_xx <= 34'(r_x * r_x);
            r_xy <= 43'(r_x * w_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_sxy <= '0;
        end else if (i_cmd.accum && r_keep) begin
            r_cnt <= r_cnt + 1'b1;
            r_sx  <= r_sx  + SX_W'(r_x);
            r_sy  <= r_sy  + SY_W'(r_y);
            r_sxx <= r_sxx + SXX_W'(r_xx);
            r_sxy <= r_sxy + SXY_W'(r_xy);
        end
    end

    // ---------------- serial multiplier: four products ----------------
    logic [1:0]            r_pidx;
    logic [BIT_CNT_W-1:0]  r_bcnt;
    logic [OP_W-1:0]       r_ma, r_mb;
    logic                  r_psg;
    logic [PROD_W-1:0]     r_acc;
    logic [PROD_W-1:0]     r_pmag [4];
    logic [3:0]            r_psgn;
    logic signed [OP_W-1:0] w_opa, w_opb;
    logic [PROD_W-1:0]     w_acc;

    always_comb begin
        unique case (r_pidx)
            2'd0: begin
                w_opa = OP_W'($signed({1'b0, r_cnt}));
                w_opb = OP_W'(r_sxy);
            end
            2'd1: begin
                w_opa = OP_W'(r_sx);
                w_opb = OP_W'(r_sy);
            end
            2'd2: begin
                w_opa = OP_W'($signed({1'b0, r_cnt}));
                w_opb = OP_W'(r_sxx);
            end
            default: begin
                w_opa = OP_W'(r_sx);
                w_opb = OP_W'(r_sx);
            end
        endcase
        w_acc = {r_acc[PROD_W-2:0], 1'b0}
              + (r_mb[r_bcnt] ? PROD_W'(r_ma) : PROD_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_pidx <= '0;
        end else if (i_cmd.prod_step && r_bcnt == '0) begin
            r_pidx <= r_pidx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod_load) begin
            r_ma   <= w_opa[OP_W-1] ? OP_W'(-w_opa) : OP_W'(w_opa);
            r_mb   <= w_opb[OP_W-1] ? OP_W'(-w_opb) : OP_W'(w_opb);
            r_psg  <= w_opa[OP_W-1] ^ w_opb[OP_W-1];
            r_acc  <= '0;
            r_bcnt <= BIT_CNT_W'(OP_W - 1);
        end else if (i_cmd.prod_step) begin
            r_acc  <= w_acc;
            r_bcnt <= r_bcnt - 1'b1;
            if (r_bcnt == '0) begin
                r_pmag[r_pidx] <= w_acc;
                r_psgn[r_pidx] <= r_psg;
            end
        end
    end

    // ---------------- numerator, denominator, divider ----------------
    logic signed [PROD_W-1:0] r_num, r_den;
    logic signed [PROD_W-1:0] w_p [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_p[k] = r_psgn[k] ? -$signed(r_pmag[k]) : $signed(r_pmag[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.form) begin
            r_num <= w_p[0] - w_p[1];
            r_den <= w_p[2] - w_p[3];
        end
    end

    logic                 r_neg, r_degen, r_prepped;
    logic [DVD_W-1:0]     r_dvd, r_q;
    logic [DSR_W-1:0]     r_dsr;
    logic [DSR_W:0]       r_rem;
    logic [DIV_CNT_W-1:0] r_dcnt;
    logic [PROD_W-1:0]    w_an, w_ad;
    logic [DSR_W+1:0]     w_trial;
    logic                 w_ge;

    always_comb begin
        w_an    = r_num[PROD_W-1] ? PROD_W'(-r_num) : PROD_W'(r_num);
        w_ad    = r_den[PROD_W-1] ? PROD_W'(-r_den) : PROD_W'(r_den);
        w_trial = {r_rem, r_dvd[DVD_W-1]};
        w_ge    = w_trial >= (DSR_W+2)'(r_dsr);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.form) begin
            r_prepped <= 1'b0;
        end else if (i_cmd.div_step) begin
            if (!r_prepped) begin
                r_prepped <= 1'b1;
                r_neg   <= r_num[PROD_W-1] ^ r_den[PROD_W-1];
                r_degen <= (r_den == '0);
                r_dvd   <= (DVD_W'(w_an) << FRAC_SHIFT) + DVD_W'(w_ad);
                r_dsr   <= {1'b0, w_ad, 1'b0};
                r_rem   <= '0;
                r_q     <= '0;
                r_dcnt  <= DIV_CNT_W'(DVD_W - 1);
            end else begin
                r_rem  <= w_ge ? (DSR_W+1)'(w_trial - (DSR_W+2)'(r_dsr))
                               : (DSR_W+1)'(w_trial);
                r_q    <= {r_q[DVD_W-2:0], w_ge};
                r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
                r_dcnt <= r_dcnt - 1'b1;
            end
        end
    end

    // ---------------- result register ----------------
    logic [SLOPE_W-1:0] w_lim, w_mag;
    logic               w_clip;

    always_comb begin
        w_lim  = r_neg ? {1'b1, {(SLOPE_W-1){1'b0}}} : {1'b0, {(SLOPE_W-1){1'b1}}};
        w_clip = (|r_q[DVD_W-1:SLOPE_W]) || (r_q[SLOPE_W-1:0] > w_lim);
        w_mag  = w_clip ? w_lim : r_q[SLOPE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_out_data.used_count <= r_cnt;
            o_out_data.degenerate <= r_degen;
            o_out_data.clipped    <= !r_degen && w_clip;
            o_out_data.slope      <= r_degen ? '0
                                   : (r_neg ? $signed(-w_mag) : $signed(w_mag));
        end
    end

    assign o_status.last       = r_last;
    assign o_status.prod_done  = (r_bcnt == '0);
    assign o_status.prod_final = (r_pidx == 2'd3);
    assign o_status.div_done   = r_prepped && (r_dcnt == '0);
    assign o_status.out_free   = !o_out_valid || !i_out_stall;

endmodule

FILE: hdl/masked_least_squares_slope.sv
// Top level: masked least-squares slope over one image
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ----------------------------
//  in        input      i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_stall o_out_data (t_out_item)
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  A pixel beat passes four steps: capture, y multiply, x*x and x*y multiply,
//  accumulate. A last-pixel beat adds the fit: four 58-step shift-add
//  products on one shared multiplier, each after an operand load; forming
//  numerator and denominator; a 104-step restoring divider after a prep
//  step; and the load of the result register, which waits for that register.
//  Synchronous active-low reset clears the sums and loads register defaults.
//  A stalled result holds in the output register; the next image is taken
//  meanwhile, and only the next result load waits for that register.
//
module masked_least_squares_slope
    import mlss_pkg::*;
#(
    parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    // Always taken; writes must arrive only while the block idles, unenforced.
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = ~w_in_ready;

    mlss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    mlss_dp #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_item      (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
